>>> rtl/http_chunked_body_decoder_top_defines.svh
// Assertion macros for the chunked body decoder.
`ifndef HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Check under reset qualification.
`define HCBD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hcbd assertion failed");
// Check at every edge, reset included.
`define HCBD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT(label, clk, rst_n, prop)
`define HCBD_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

  localparam int MAX_SIZE_LINE = 4096;
  localparam int LINE_W = $clog2(MAX_SIZE_LINE + 1);
  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(MAX_SIZE_LINE);

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN   = 2'd2;

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_DONE     = 3'd1,
    ST_BADSIZE  = 3'd2,
    ST_LONGLINE = 3'd3,
    ST_LENGTH   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CLS_HEX   = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_CR    = 3'd2,
    CLS_LF    = 3'd3,
    CLS_OTHER = 3'd4
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic        chunked;
    logic [31:0] expected;
    logic [31:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       pvalid;
    status_t    status;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/hcbd_front.sv
`default_nettype none
module hcbd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       rx_byte,
  input  logic             push,
  output logic             full,
  input  logic             pop,
  output hcbd_pkg::q_head_t head
);
  import hcbd_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;
  item_t          cls_item;

  // Tag each byte with its class and hex digit value.
  function automatic item_t classify(input logic [7:0] b);
    item_t it;
    it.data  = b;
    it.digit = 4'h0;
    it.cls   = CLS_OTHER;
    if (b >= 8'h30 && b <= 8'h39) begin
      it.cls   = CLS_HEX;
      it.digit = b[3:0];
    end else if (b >= 8'h41 && b <= 8'h46) begin
      it.cls   = CLS_HEX;
      it.digit = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      it.cls   = CLS_HEX;
      it.digit = 4'(b - 8'h57);
    end else if (b == 8'h20) begin
      it.cls = CLS_SPACE;
    end else if (b == 8'h0D) begin
      it.cls = CLS_CR;
    end else if (b == 8'h0A) begin
      it.cls = CLS_LF;
    end
    return it;
  endfunction

  assign cls_item   = classify(rx_byte);
  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign do_push    = push & ~full;
  assign do_pop     = pop & (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(do_push);
    rd_ptr_nxt = rd_ptr_r + QAW'(do_pop);
    cnt_nxt    = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/hcbd_back.sv
`default_nettype none
module hcbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hcbd_pkg::cfg_t    cfg,
  input  hcbd_pkg::q_head_t head,
  output logic              pop,
  output logic [7:0]        res_byte,
  output logic              res_valid,
  output logic [2:0]        res_status,
  output logic              res_empty,
  input  logic              res_pop
);
  import hcbd_pkg::*;

  // Decode state.
  logic              data_r, data_nxt;
  logic [31:0]       left_r, left_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              dig_r, dig_nxt;
  logic              bad_r, bad_nxt;
  logic              past_r, past_nxt;
  logic              cr_r, cr_nxt;
  logic [LINE_W-1:0] len_r, len_nxt;
  logic [31:0]       recv_r, recv_nxt;
  status_t           status_r, status_nxt;

  // Two-entry result buffer.
  res_t       buf_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_rpop, step;
  res_t       res;
  item_t      it;
  logic       over;
  logic       exceed;

  assign it        = head.item;
  assign do_rpop   = res_pop & (cnt_r != 2'd0);
  assign step      = head.valid & ((cnt_r != 2'd2) | do_rpop);
  assign pop       = step;
  assign res_empty = (cnt_r == 2'd0);
  assign res_byte   = buf_r[rd_r].pbyte;
  assign res_valid  = buf_r[rd_r].pvalid;
  assign res_status = buf_r[rd_r].status;

  always_comb begin
    data_nxt   = data_r;
    left_nxt   = left_r;
    acc_nxt    = acc_r;
    dig_nxt    = dig_r;
    bad_nxt    = bad_r;
    past_nxt   = past_r;
    cr_nxt     = cr_r;
    len_nxt    = len_r;
    recv_nxt   = recv_r;
    status_nxt = status_r;
    over       = 1'b0;
    exceed     = 1'b0;
    res.pbyte  = 8'h00;
    res.pvalid = 1'b0;

    if (status_r == ST_RUN) begin
      over     = (recv_r == '1);
      recv_nxt = over ? recv_r : recv_r + 32'd1;

      if (!cfg.chunked) begin
        res.pbyte  = it.data;
        res.pvalid = 1'b1;
      end else if (data_r && left_r != '0) begin
        res.pbyte  = it.data;
        res.pvalid = 1'b1;
        left_nxt   = left_r - 32'd1;
        if (left_r == 32'd1) begin
          data_nxt = 1'b0;
        end
      end else begin
        data_nxt = 1'b0;
        if (cr_r && it.cls == CLS_LF) begin
          // Line ends: an empty line is skipped.
          if (len_r > LINE_W'(1)) begin
            if (bad_r || !dig_r) begin
              status_nxt = ST_BADSIZE;
            end else if (acc_r == '0) begin
              status_nxt = ST_DONE;
            end else begin
              left_nxt = acc_r;
              data_nxt = 1'b1;
            end
          end
          acc_nxt  = '0;
          dig_nxt  = 1'b0;
          bad_nxt  = 1'b0;
          past_nxt = 1'b0;
          cr_nxt   = 1'b0;
          len_nxt  = '0;
        end else if (len_r >= LINE_MAX) begin
          status_nxt = ST_LONGLINE;
        end else begin
          len_nxt = len_r + LINE_W'(1);
          // A held CR that is not followed by LF is a plain non-hex byte.
          if (cr_r && !past_r) begin
            bad_nxt = 1'b1;
          end
          cr_nxt = 1'b0;
          if (it.cls == CLS_CR) begin
            cr_nxt = 1'b1;
          end else if (!past_r) begin
            case (it.cls)
              CLS_SPACE: begin
                past_nxt = 1'b1;
                if (!dig_r) begin
                  bad_nxt = 1'b1;
                end
              end
              CLS_HEX: begin
                if (acc_r[31:28] != 4'h0) begin
                  bad_nxt = 1'b1;
                end
                acc_nxt = {acc_r[27:0], it.digit};
                dig_nxt = 1'b1;
              end
              default: begin
                bad_nxt = 1'b1;
              end
            endcase
          end
        end
      end

      if (status_nxt == ST_RUN || status_nxt == ST_DONE) begin
        if (cfg.expected != '0 && (over || recv_nxt > cfg.expected)) begin
          exceed = 1'b1;
        end
        if (cfg.max_len != '0 && (over || recv_nxt > cfg.max_len)) begin
          exceed = 1'b1;
        end
        if (exceed) begin
          status_nxt = ST_LENGTH;
        end
      end
    end
    res.status = status_nxt;
  end

  always_comb begin
    cnt_nxt = cnt_r + 2'(step) - 2'(do_rpop);
  end

  always_ff @(posedge clk) begin
    if (step) begin
      buf_r[wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r   <= 1'b0;
      left_r   <= '0;
      acc_r    <= '0;
      dig_r    <= 1'b0;
      bad_r    <= 1'b0;
      past_r   <= 1'b0;
      cr_r     <= 1'b0;
      len_r    <= '0;
      recv_r   <= '0;
      status_r <= ST_RUN;
      rd_r     <= 1'b0;
      wr_r     <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (step) begin
        data_r   <= data_nxt;
        left_r   <= left_nxt;
        acc_r    <= acc_nxt;
        dig_r    <= dig_nxt;
        bad_r    <= bad_nxt;
        past_r   <= past_nxt;
        cr_r     <= cr_nxt;
        len_r    <= len_nxt;
        recv_r   <= recv_nxt;
        status_r <= status_nxt;
        wr_r     <= ~wr_r;
      end
      if (do_rpop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/http_chunked_body_decoder_top.sv
// HTTP chunked body decoder. Push one raw body byte per request; pop one
// result per byte (decoded byte, payload flag, sticky status). Throughput is
// one byte per cycle on both sides while neither stalls; a byte's result is
// registered in the queue and then in the result buffer. A four-entry queue
// sits behind the classifier and a two-entry result buffer behind the decoder,
// so either side may stall without stopping the other until the queue fills.
// Write the configuration registers only while no request is in flight.
`default_nettype none
`include "http_chunked_body_decoder_top_defines.svh"
module http_chunked_body_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_push,
  output logic                           in_full,
  // result channel
  output logic [7:0]                     out_payload_byte,
  output logic                           out_payload_valid,
  output logic [2:0]                     out_status,
  output logic                           out_empty,
  input  logic                           out_pop,
  // configuration
  input  logic                           cfg_we,
  input  logic [hcbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hcbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hcbd_pkg::*;

  cfg_t    cfg_r;
  q_head_t q_head;
  logic    q_pop;

  // Hold configuration; ignore writes to unused indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHUNKED:  cfg_r.chunked  <= cfg_data[0];
        CFG_EXPECTED: cfg_r.expected <= cfg_data;
        CFG_MAXLEN:   cfg_r.max_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify and queue each request.
  hcbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_byte (in_rx_byte),
    .push    (in_push),
    .full    (in_full),
    .pop     (q_pop),
    .head    (q_head)
  );

  // Back: advance the chunk parser and buffer results.
  hcbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_head),
    .pop        (q_pop),
    .res_byte   (out_payload_byte),
    .res_valid  (out_payload_valid),
    .res_status (out_status),
    .res_empty  (out_empty),
    .res_pop    (out_pop)
  );

  // Non-payload results carry a zero byte.
  `HCBD_ASSERT(a_zero_byte, clk, rst_n, !out_empty && !out_payload_valid |-> out_payload_byte == 8'h00)
  // Payload comes only with a running or length-exceeded status.
  `HCBD_ASSERT(a_valid_status, clk, rst_n, !out_empty && out_payload_valid |-> out_status == ST_RUN || out_status == ST_LENGTH)
  // Reset drains both queues.
  `HCBD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> out_empty && !in_full)

endmodule
`default_nettype wire

>>> verif/http_chunked_body_decoder_top_tb.sv
`timescale 1ns / 1ps
module http_chunked_body_decoder_top_tb;
  import hcbd_pkg::*;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam int RANDOM_ITEMS = 900;
  localparam int TIMEOUT_NS = 2_000_000;

  // Tracks the decoder's state per accepted request and holds the decoded
  // bytes it predicts until the block hands them out.
  class decoded_byte_checker;
    logic        chunked;
    logic [31:0] expected_len;
    logic [31:0] max_len;
    status_t     status;
    logic        in_data;
    logic [31:0] chunk_left;
    logic [31:0] size_acc;
    logic        digits_seen;
    logic        size_bad;
    logic        past_space;
    logic        cr_pending;
    int unsigned line_len;
    logic [31:0] rx_count;
    res_t        decoded_q[$];
    int          mismatches;

    function new();
      chunked      = 1'b0;
      expected_len = '0;
      max_len      = '0;
      status       = ST_RUN;
      in_data      = 1'b0;
      chunk_left   = '0;
      rx_count     = '0;
      mismatches   = 0;
      clear_line();
    endfunction

    function void clear_line();
      size_acc    = '0;
      digits_seen = 1'b0;
      size_bad    = 1'b0;
      past_space  = 1'b0;
      cr_pending  = 1'b0;
      line_len    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_CHUNKED:  chunked = val[0];
        CFG_EXPECTED: expected_len = val;
        CFG_MAXLEN:   max_len = val;
        default: ;
      endcase
    endfunction

    // Fold one size-line byte into the hex value; ignore all past the space.
    function void take_line_char(logic [7:0] c);
      logic [3:0] nib;
      if (past_space) return;
      if (c == CH_SP) begin
        past_space = 1'b1;
        if (!digits_seen) size_bad = 1'b1;
        return;
      end
      if (c >= "0" && c <= "9") nib = 4'(c - "0");
      else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
      else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
      else begin
        size_bad = 1'b1;
        return;
      end
      if (size_acc[31:28] != 4'd0) size_bad = 1'b1;
      size_acc    = {size_acc[27:0], nib};
      digits_seen = 1'b1;
    endfunction

    function void note_rx_byte(logic [7:0] c);
      res_t r;
      logic saturated;
      logic exceed;
      r.pbyte  = 8'h00;
      r.pvalid = 1'b0;
      if (status == ST_RUN) begin
        saturated = (rx_count == 32'hFFFF_FFFF);
        if (!saturated) rx_count = rx_count + 32'd1;
        if (!chunked) begin
          r.pbyte  = c;
          r.pvalid = 1'b1;
        end else if (in_data && chunk_left != 32'd0) begin
          r.pbyte    = c;
          r.pvalid   = 1'b1;
          chunk_left = chunk_left - 32'd1;
          if (chunk_left == 32'd0) in_data = 1'b0;
        end else begin
          in_data = 1'b0;
          if (cr_pending && c == CH_LF) begin
            // an empty line (only the CR held) is skipped
            if (line_len > 1) begin
              if (size_bad || !digits_seen) status = ST_BADSIZE;
              else if (size_acc == 32'd0) status = ST_DONE;
              else begin
                chunk_left = size_acc;
                in_data    = 1'b1;
              end
            end
            clear_line();
          end else if (line_len >= MAX_SIZE_LINE) begin
            status = ST_LONGLINE;
          end else begin
            line_len++;
            if (cr_pending) begin
              take_line_char(CH_CR);
              cr_pending = 1'b0;
            end
            if (c == CH_CR) cr_pending = 1'b1;
            else take_line_char(c);
          end
        end
        if (status == ST_RUN || status == ST_DONE) begin
          exceed = (expected_len != 0 && (saturated || rx_count > expected_len)) ||
                   (max_len != 0 && (saturated || rx_count > max_len));
          if (exceed) status = ST_LENGTH;
        end
      end
      r.status = status;
      decoded_q.push_back(r);
    endfunction

    function void check_decoded(logic [7:0] pb, logic pv, logic [2:0] st);
      res_t want;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %02h valid %0d status %0d", pb, pv, st);
        return;
      end
      want = decoded_q.pop_front();
      if (pb !== want.pbyte || pv !== want.pvalid || st !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte %02h valid %0d status %0d, got %02h %0d %0d",
                   want.pbyte, want.pvalid, want.status, pb, pv, st);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [7:0]            out_payload_byte;
  logic                  out_payload_valid;
  logic [2:0]            out_status;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CHUNKED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  decoded_byte_checker decoder_model = new();

  // Raw body bytes waiting to be sent, and the count of requests accepted.
  logic [7:0]  burst[$];
  int unsigned pushed = 0;
  // Set during the stretch where neither side idles.
  bit          calm = 1'b0;

  http_chunked_body_decoder_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .in_push          (in_push),
    .in_full          (in_full),
    .out_payload_byte (out_payload_byte),
    .out_payload_valid(out_payload_valid),
    .out_status       (out_status),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check whatever pops at this edge, then pick next edge's pop.
  // Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      decoder_model.check_decoded(out_payload_byte, out_payload_valid, out_status);
    out_pop <= rst_n && (calm || $urandom_range(99) >= 19);
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("http_chunked_body_decoder_top_tb: errors");
    $finish;
  end

  // Send burst[lo..hi-1], one request per byte. Hold push high across
  // back-to-back requests; drop it only to idle or when the range is done,
  // and let an edge pass after the drop.
  task automatic send_bytes(int lo, int hi);
    int i;
    if (lo >= hi) return;
    for (i = lo; i < hi; i++) begin
      while (!calm && $urandom_range(99) < 19) begin
        in_push <= 1'b0;
        @(posedge clk);
      end
      in_push    <= 1'b1;
      in_rx_byte <= burst[i];
      @(posedge clk);
      while (in_full) @(posedge clk);
      decoder_model.note_rx_byte(burst[i]);
      pushed++;
    end
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_all();
    send_bytes(0, burst.size());
    burst.delete();
  endtask

  // Wait until every predicted result has popped, then wait out a margin.
  task automatic settle();
    while (decoder_model.decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    decoder_model.set_reg(idx, val);
  endtask

  // Reprogram all registers; only legal once the block has drained.
  task automatic configure(logic ch, logic [31:0] ex, logic [31:0] mx);
    settle();
    write_reg(CFG_CHUNKED, {31'd0, ch});
    write_reg(CFG_EXPECTED, ex);
    write_reg(CFG_MAXLEN, mx);
    cfg_we <= 1'b0;
  endtask

  function automatic void put_crlf();
    burst.push_back(CH_CR);
    burst.push_back(CH_LF);
  endfunction

  // Hex size with random letter case and optional leading zeros.
  function automatic void put_hex(logic [31:0] v, int zeros);
    int n;
    int i;
    logic [3:0] nib;
    logic [7:0] ch;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    repeat (zeros) burst.push_back("0");
    for (i = n - 1; i >= 0; i--) begin
      nib = v[4 * i +: 4];
      if (nib < 4'd10) ch = 8'h30 + 8'(nib);
      else ch = ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
      burst.push_back(ch);
    end
  endfunction

  // Space plus n arbitrary bytes; never a CR directly followed by LF.
  function automatic void put_ext(int n);
    logic [7:0] b;
    burst.push_back(CH_SP);
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == CH_LF && burst[$] == CH_CR) b = ";";
      burst.push_back(b);
    end
  endfunction

  // Whole chunk: size line, data, closing CRLF, sometimes an extra empty
  // line. Return where the data starts.
  function automatic int put_chunk(int unsigned size);
    int head;
    put_hex(size, ($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0);
    if ($urandom_range(2) == 0) put_ext($urandom_range(8));
    put_crlf();
    head = burst.size();
    repeat (size) burst.push_back(8'($urandom_range(255)));
    put_crlf();
    if ($urandom_range(5) == 0) put_crlf();
    return head;
  endfunction

  // Limit at an extreme or far beyond anything this run can reach.
  function automatic logic [31:0] far_limit();
    case ($urandom_range(2))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return decoder_model.rx_count + 32'd100000 + 32'($urandom_range(1000));
    endcase
  endfunction

  initial begin
    int unsigned start;
    int unsigned size;
    int head;
    int cut;
    int plain_at;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain body: every byte passes, control characters included.
    configure(1'b0, 32'hFFFF_FFFF, 32'd0);
    burst = '{8'h00, 8'hFF, CH_CR, CH_LF, CH_SP, 8'h5A};
    send_all();

    // Chunked: extension with a lone CR, an empty line, leading zeros, and
    // data holding CR LF that must pass as payload.
    configure(1'b1, 32'd0, 32'hFFFF_FFFF);
    burst = '{"1", CH_SP, "e", CH_CR, "z", CH_CR, CH_LF, 8'hA5, CH_CR, CH_LF,
              CH_CR, CH_LF, "0", "0", "3", CH_CR, CH_LF, 8'h00, CH_CR, CH_LF,
              CH_CR, CH_LF};
    send_all();

    // Random well-formed chunks in phases, with plain-mode bursts and mode
    // flips in the middle of chunk data.
    start = pushed;
    while (pushed < start + RANDOM_ITEMS) begin
      calm = (pushed >= start + 300 && pushed < start + 550);
      configure(1'b1, far_limit(), far_limit());
      repeat ($urandom_range(1, 5)) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
        head = put_chunk(size);
        if ($urandom_range(11) == 0) begin
          // Go plain partway through the data; the chunk count must hold.
          cut = head + $urandom_range(size - 1);
          plain_at = burst.size();
          repeat ($urandom_range(1, 12)) burst.push_back(8'($urandom_range(255)));
          send_bytes(0, cut);
          configure(1'b0, decoder_model.expected_len, decoder_model.max_len);
          send_bytes(plain_at, burst.size());
          configure(1'b1, decoder_model.expected_len, decoder_model.max_len);
          send_bytes(cut, plain_at);
          burst.delete();
        end else begin
          send_all();
        end
      end
      if ($urandom_range(3) == 0) begin
        configure(1'b0, decoder_model.expected_len, decoder_model.max_len);
        repeat ($urandom_range(10, 40)) burst.push_back(8'($urandom_range(255)));
        send_all();
      end
    end
    calm = 1'b0;

    // Close the body in one of the terminal ways; status sticks after it.
    configure(1'b1, far_limit(), far_limit());
    case ($urandom_range(4))
      0: begin
        // Zero chunk, then trailers that must be ignored.
        put_hex(32'd0, $urandom_range(2));
        if ($urandom_range(1)) put_ext(3);
        put_crlf();
        put_ext(10);
        put_crlf();
        put_crlf();
      end
      1: begin
        case ($urandom_range(4))
          0: burst = '{"1", "g"};
          1: begin
            // nine significant digits overflow 32 bits
            put_hex(32'h1000_0000 | 32'($urandom), 0);
            burst.push_back("7");
          end
          2: put_ext(2);
          3: burst = '{"1", CH_CR, "2"};
          default: burst = '{"5", CH_LF};
        endcase
        put_crlf();
      end
      2: begin
        // A line of exactly the limit is fine; one byte more is not.
        burst.push_back("1");
        put_ext(MAX_SIZE_LINE - 3);
        put_crlf();
        burst.push_back(8'($urandom_range(255)));
        put_crlf();
        burst.push_back("2");
        put_ext(MAX_SIZE_LINE + 4);
      end
      3: begin
        configure(1'b1, decoder_model.rx_count + 32'($urandom_range(1, 40)), 32'd0);
        repeat (3) void'(put_chunk(16));
      end
      default: begin
        // Exceed the limit on the LF that would finish the body.
        configure(1'b1, 32'd0, decoder_model.rx_count + 32'd2);
        burst = '{"0"};
        put_crlf();
      end
    endcase
    send_all();
    configure(1'($urandom_range(1)), 32'd0, 32'd0);
    repeat (20) burst.push_back(8'($urandom_range(255)));
    send_all();

    settle();
    repeat (6) @(posedge clk);
    if (decoder_model.mismatches == 0 && decoder_model.decoded_q.size() == 0)
      $display("http_chunked_body_decoder_top_tb: clean");
    else
      $display("http_chunked_body_decoder_top_tb: errors");
    $finish;
  end

endmodule
